### design/ptpd_pkg.sv
// ----------------------------------------------------------------------------
// ptpd_pkg
// Shared types and constants for the point transform with perspective divide.
// ----------------------------------------------------------------------------
package ptpd_pkg;

	localparam int FracBitsDefault = 16;
	localparam int NumRegs = 8;
	localparam int RegW = 64;
	localparam int RegIdxW = 3;
	localparam int CoordW = 32;
	// sum of three shifted full products plus translation, lossless
	localparam int SumW = 2 * CoordW;

	typedef logic signed [CoordW-1:0] coord_t;

	// one transaction leaving the front part: clamped sums and control
	typedef struct packed {
		coord_t sx;
		coord_t sy;
		coord_t sz;
		coord_t sw;
		logic do_div;
		logic dz;
		logic sat;
	} ptpd_cls_t;

	// result of the back part
	typedef struct packed {
		coord_t ox;
		coord_t oy;
		coord_t oz;
		logic dz;
		logic sat;
	} ptpd_res_t;

	// clamp a wide signed sum to 32 bits
	function automatic logic [CoordW:0] clamp_sum(input logic signed [SumW-1:0] v);
		logic [CoordW:0] r;
		if (v > SumW'(64'sd2147483647)) r = {1'b1, 32'h7fffffff};
		else if (v < SumW'(-64'sd2147483648)) r = {1'b1, 32'h80000000};
		else r = {1'b0, v[CoordW-1:0]};
		return r;
	endfunction

endpackage

### design/ptpd_front.sv
// ----------------------------------------------------------------------------
// ptpd_front
// Multiplies the point by the matrix, clamps the sums and classifies w
// (exact one, zero, general divide) in three pipeline stages.
// ----------------------------------------------------------------------------
module ptpd_front import ptpd_pkg::*; #(
	parameter int FRAC_BITS = FracBitsDefault
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [RegW-1:0]       regs [NumRegs],
	input  logic                  in_valid,
	output logic                  in_ready,
	input  coord_t                px,
	input  coord_t                py,
	input  coord_t                pz,
	output logic                  cls_valid,
	input  logic                  cls_ready,
	output ptpd_cls_t             cls
);

	logic signed [CoordW-1:0] coef [4][4];
	logic signed [2*CoordW-1:0] prod_s1 [3][4];
	logic signed [SumW-1:0] sum_s2 [4];
	logic v_s1, v_s2, v_s3;
	ptpd_cls_t cls_s3;
	logic adv;

	// stall whole pipe when output held
	assign adv = !v_s3 || cls_ready;
	assign in_ready = adv;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			coef[r][0] = regs[r*2][31:0];
			coef[r][1] = regs[r*2][63:32];
			coef[r][2] = regs[r*2+1][31:0];
			coef[r][3] = regs[r*2+1][63:32];
		end
	end

	// stage 1: twelve products
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				prod_s1[0][c] <= 64'(px) * 64'(coef[0][c]);
				prod_s1[1][c] <= 64'(py) * 64'(coef[1][c]);
				prod_s1[2][c] <= 64'(pz) * 64'(coef[2][c]);
			end
		end
	end

	// stage 2: floor shift and sum with translation
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int c = 0; c < 4; c++) begin
				sum_s2[c] <= SumW'(coef[3][c]) + SumW'(prod_s1[0][c] >>> FRAC_BITS)
					+ SumW'(prod_s1[1][c] >>> FRAC_BITS)
					+ SumW'(prod_s1[2][c] >>> FRAC_BITS);
			end
		end
	end

	// stage 3: clamp and classify
	always_ff @(posedge clk) begin
		logic [CoordW:0] cx, cy, cz, cw;
		cx = clamp_sum(sum_s2[0]);
		cy = clamp_sum(sum_s2[1]);
		cz = clamp_sum(sum_s2[2]);
		cw = clamp_sum(sum_s2[3]);
		if (adv) begin
			cls_s3.sx <= cx[CoordW-1:0];
			cls_s3.sy <= cy[CoordW-1:0];
			cls_s3.sz <= cz[CoordW-1:0];
			cls_s3.sw <= cw[CoordW-1:0];
			cls_s3.dz <= cw[CoordW-1:0] == '0;
			cls_s3.do_div <= cw[CoordW-1:0] != '0
				&& cw[CoordW-1:0] != (CoordW'(1) << FRAC_BITS);
			cls_s3.sat <= cx[CoordW] | cy[CoordW] | cz[CoordW] | cw[CoordW];
		end
	end

	// valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign cls_valid = v_s3;
	assign cls = cls_s3;

endmodule

### design/ptpd_fifo.sv
// ----------------------------------------------------------------------------
// ptpd_fifo
// Short queue between the front and back parts.
// ----------------------------------------------------------------------------
module ptpd_fifo import ptpd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      wr_valid,
	output logic      wr_ready,
	input  ptpd_cls_t wr_data,
	output logic      rd_valid,
	input  logic      rd_ready,
	output ptpd_cls_t rd_data
);

	ptpd_cls_t mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != 3'd4;
	assign rd_valid = cnt_q != 3'd0;
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	// pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= wp_q + 2'd1;
			if (rd) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr) - 3'(rd);
		end
	end

endmodule

### design/ptpd_back.sv
// ----------------------------------------------------------------------------
// ptpd_back
// Pipelined restoring divider: three lanes share w, one quotient bit per
// stage, then sign fix, clamp and output register.
// ----------------------------------------------------------------------------
module ptpd_back import ptpd_pkg::*; #(
	parameter int FRAC_BITS = FracBitsDefault
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cls_valid,
	output logic      cls_ready,
	input  ptpd_cls_t cls,
	output logic      res_valid,
	input  logic      res_ready,
	output ptpd_res_t res
);

	// dividend is the magnitude shifted up by the fraction bits
	localparam int DivQW = CoordW + FRAC_BITS;
	localparam int NS = DivQW;
	localparam int NW = DivQW + 1;

	// per-stage state; the top valid bit belongs to the output register
	logic [NS+1:0] v_q;
	logic [DivQW-1:0] rem_q [NS+1][3];
	logic [DivQW-1:0] quo_q [NS+1][3];
	logic [CoordW-1:0] dv_q [NS+1];
	logic neg_q [NS+1][3];
	coord_t raw_q [NS+1][3];
	logic div_q [NS+1];
	logic dz_q [NS+1];
	logic sat_q [NS+1];
	logic adv;

	assign adv = !v_q[NS+1] || res_ready;
	assign cls_ready = adv;

	// stage 0: magnitudes
	always_ff @(posedge clk) begin
		logic [CoordW-1:0] aw;
		logic [CoordW-1:0] an;
		aw = cls.sw[CoordW-1] ? CoordW'(-cls.sw) : cls.sw;
		if (adv) begin
			dv_q[0] <= aw;
			div_q[0] <= cls.do_div;
			dz_q[0] <= cls.dz;
			sat_q[0] <= cls.sat;
			raw_q[0][0] <= cls.sx;
			raw_q[0][1] <= cls.sy;
			raw_q[0][2] <= cls.sz;
			for (int l = 0; l < 3; l++) begin
				an = l == 0 ? cls.sx : (l == 1 ? cls.sy : cls.sz);
				neg_q[0][l] <= an[CoordW-1] ^ cls.sw[CoordW-1];
				an = an[CoordW-1] ? CoordW'(-an) : an;
				quo_q[0][l] <= DivQW'({an, FRAC_BITS'(0)});
				rem_q[0][l] <= '0;
			end
		end
	end

	// divide stages
	for (genvar s = 0; s < NS; s++) begin : g_div
		always_ff @(posedge clk) begin
			logic [NW-1:0] t;
			if (adv) begin
				dv_q[s+1] <= dv_q[s];
				div_q[s+1] <= div_q[s];
				dz_q[s+1] <= dz_q[s];
				sat_q[s+1] <= sat_q[s];
				for (int l = 0; l < 3; l++) begin
					raw_q[s+1][l] <= raw_q[s][l];
					neg_q[s+1][l] <= neg_q[s][l];
					t = {rem_q[s][l], quo_q[s][l][DivQW-1]};
					if (t >= NW'(dv_q[s])) begin
						rem_q[s+1][l] <= DivQW'(t - NW'(dv_q[s]));
						quo_q[s+1][l] <= {quo_q[s][l][DivQW-2:0], 1'b1};
					end else begin
						rem_q[s+1][l] <= DivQW'(t);
						quo_q[s+1][l] <= {quo_q[s][l][DivQW-2:0], 1'b0};
					end
				end
			end
		end
	end

	// sign, clamp and output register
	always_ff @(posedge clk) begin
		logic [DivQW-1:0] q;
		logic ov;
		logic sat;
		coord_t o [3];
		sat = sat_q[NS];
		for (int l = 0; l < 3; l++) begin
			q = quo_q[NS][l];
			o[l] = raw_q[NS][l];
			if (div_q[NS]) begin
				if (neg_q[NS][l]) begin
					ov = q > DivQW'(33'h80000000);
					o[l] = ov ? coord_t'(32'h80000000) : coord_t'(-q[CoordW-1:0]);
				end else begin
					ov = q > DivQW'(32'h7fffffff);
					o[l] = ov ? coord_t'(32'h7fffffff) : coord_t'(q[CoordW-1:0]);
				end
				sat = sat | ov;
			end
		end
		if (adv) begin
			res.ox <= o[0];
			res.oy <= o[1];
			res.oz <= o[2];
			res.dz <= dz_q[NS];
			res.sat <= sat;
		end
	end

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_q <= '0;
		else if (adv) v_q <= {v_q[NS:0], cls_valid};
	end

	assign res_valid = v_q[NS+1];

endmodule

### design/point_transform_perspective_divide.sv
// ----------------------------------------------------------------------------
// point_transform_perspective_divide
// Homogeneous 4x4 point transform with perspective divide, Q16.16.
// ----------------------------------------------------------------------------
// Takes one point per cycle and delivers one result per cycle while out_ready
// is held high. A point passes the matrix multiply and clamp stages, the
// four-entry queue, the divider entry register, a restoring divider with one
// quotient bit per stage (32 plus FRAC_BITS stages) and the output register.
// The matrix resets to identity; the user must write it through
// cfg_we/cfg_index/cfg_data only while the block is idle, which the block
// itself does not enforce.
module point_transform_perspective_divide import ptpd_pkg::*; #(
	parameter int FRAC_BITS = FracBitsDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [RegIdxW:0]    cfg_index,
	input  logic [RegW-1:0]     cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  coord_t              point_x,
	input  coord_t              point_y,
	input  coord_t              point_z,
	output logic                out_valid,
	input  logic                out_ready,
	output coord_t              out_x,
	output coord_t              out_y,
	output coord_t              out_z,
	output logic                divide_by_zero,
	output logic                saturated
);

	localparam logic [RegW-1:0] One = RegW'(1) << FRAC_BITS;

	logic [RegW-1:0] regs_q [NumRegs];
	logic fv, fr, qv, qr;
	ptpd_cls_t fd, qd;
	ptpd_res_t res;

	// matrix registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q[0] <= One;
			regs_q[1] <= '0;
			regs_q[2] <= One << 32;
			regs_q[3] <= '0;
			regs_q[4] <= '0;
			regs_q[5] <= One;
			regs_q[6] <= '0;
			regs_q[7] <= One << 32;
		end else if (cfg_we && !cfg_index[RegIdxW]) begin
			regs_q[cfg_index[RegIdxW-1:0]] <= cfg_data;
		end
	end

	ptpd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk, .arst_n, .regs(regs_q), .in_valid, .in_ready,
		.px(point_x), .py(point_y), .pz(point_z),
		.cls_valid(fv), .cls_ready(fr), .cls(fd)
	);

	ptpd_fifo u_fifo (
		.clk, .arst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fd),
		.rd_valid(qv), .rd_ready(qr), .rd_data(qd)
	);

	ptpd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .cls_valid(qv), .cls_ready(qr), .cls(qd),
		.res_valid(out_valid), .res_ready(out_ready), .res
	);

	assign out_x = res.ox;
	assign out_y = res.oy;
	assign out_z = res.oz;
	assign divide_by_zero = res.dz;
	assign saturated = res.sat;

endmodule
